// ===== hw/rtl/mpct_pkg.sv =====
// Shared constants, types and arithmetic helpers for the pointer and click tracker.
`timescale 1ns / 1ps

package mpct_pkg;

  localparam int CoordW = 12;
  localparam int CountW = 8;
  localparam int DeltaW = 9;
  localparam int EvW    = 2;
  localparam int RegIdxW = 2;
  localparam int CfgDataW = 12;

  // Register indexes of the configuration port.
  localparam logic [RegIdxW-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [RegIdxW-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_WINDOW  = 2'd2;

  // Release event codes.
  localparam logic [EvW-1:0] EV_NONE   = 2'd0;
  localparam logic [EvW-1:0] EV_CLICK  = 2'd1;
  localparam logic [EvW-1:0] EV_DOUBLE = 2'd2;

  localparam logic [CoordW-1:0] X_LIMIT_RESET = 12'd639;
  localparam logic [CoordW-1:0] Y_LIMIT_RESET = 12'd479;
  localparam logic [CountW-1:0] WINDOW_RESET  = 8'd20;

  typedef struct packed {
    logic           down;
    logic [EvW-1:0] ev;
  } btn_status_t;

  // Difference of two byte counters, folded back into -128..128.
  function automatic logic signed [DeltaW-1:0] wrap_delta(
    input logic signed [7:0] now_c,
    input logic signed [7:0] old_c
  );
    logic signed [9:0] d;
    d = 10'(now_c) - 10'(old_c);
    if (d < -10'sd128) begin
      d = d + 10'sd256;
    end else if (d > 10'sd128) begin
      d = d - 10'sd256;
    end
    return d[DeltaW-1:0];
  endfunction

  // Move one coordinate and clamp it to 1..limit, with limit minus 1 above.
  function automatic logic [CoordW-1:0] move_axis(
    input logic [CoordW-1:0]        pos,
    input logic signed [DeltaW-1:0] d,
    input logic [CoordW-1:0]        limit
  );
    logic signed [13:0] sum;
    logic signed [13:0] lim_s;
    sum   = $signed({2'b00, pos}) + 14'(d);
    lim_s = $signed({2'b00, limit});
    if (sum < 14'sd1) begin
      return 12'd1;
    end else if (sum > lim_s) begin
      return limit - 12'd1;
    end else begin
      return sum[CoordW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mpct_if.sv =====
// Handshake interfaces for the poll, result and configuration channels.
`timescale 1ns / 1ps

interface mpct_poll_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] x_counter;
  logic signed [7:0] y_counter;
  logic              left_raw_n;
  logic              right_raw_n;
  logic              middle_raw_n;

  modport source (output valid, x_counter, y_counter, left_raw_n, right_raw_n,
                  middle_raw_n, input ready);
  modport sink   (input valid, x_counter, y_counter, left_raw_n, right_raw_n,
                  middle_raw_n, output ready);
endinterface

interface mpct_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [mpct_pkg::CoordW-1:0]          pointer_x;
  logic [mpct_pkg::CoordW-1:0]          pointer_y;
  logic signed [mpct_pkg::DeltaW-1:0]   delta_x;
  logic signed [mpct_pkg::DeltaW-1:0]   delta_y;
  logic                                 left_down;
  logic [mpct_pkg::EvW-1:0]             left_event;
  logic                                 right_down;
  logic [mpct_pkg::EvW-1:0]             right_event;
  logic                                 middle_down;
  logic [mpct_pkg::EvW-1:0]             middle_event;

  modport source (output valid, pointer_x, pointer_y, delta_x, delta_y, left_down,
                  left_event, right_down, right_event, middle_down, middle_event,
                  input ready);
  modport sink   (input valid, pointer_x, pointer_y, delta_x, delta_y, left_down,
                  left_event, right_down, right_event, middle_down, middle_event,
                  output ready);
endinterface

interface mpct_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpct_pkg::RegIdxW-1:0]  index;
  logic [mpct_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mpct_button.sv =====
// One button: held level, release detection and double-click window counter.
`timescale 1ns / 1ps

module mpct_button (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          raw_n,
  input  logic [mpct_pkg::CountW-1:0]   window,
  output mpct_pkg::btn_status_t         status
);

  logic                        last_pressed;
  logic [mpct_pkg::CountW-1:0] count;
  logic [mpct_pkg::CountW-1:0] count_dec;
  logic [mpct_pkg::CountW-1:0] count_next;
  logic                        now_pressed;

  always_comb begin
    now_pressed = !raw_n;
    count_dec   = (count != '0) ? count - 8'd1 : count;
    count_next  = count_dec;
    status.down = now_pressed;
    status.ev   = mpct_pkg::EV_NONE;
    if (!now_pressed && last_pressed) begin
      if (count_dec == '0) begin
        status.ev  = mpct_pkg::EV_CLICK;
        count_next = window;
      end else begin
        status.ev = mpct_pkg::EV_DOUBLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed <= 1'b0;
      count        <= '0;
    end else if (step) begin
      last_pressed <= now_pressed;
      count        <= count_next;
    end
  end

endmodule

// ===== hw/rtl/mouse_pointer_click_tracker.sv =====
// Top level of the mouse pointer and click tracker.
// Path: a poll beat is captured in the input register and its result then in the result register.
// Throughput: one poll per cycle while the result side is not stalled; the input register and the result register
// each hand on a beat every cycle that the result side is not stalled.
// Reset: synchronous, clears both pipeline valids, the counters, cursor (to 1)
// and button history, and restores the limits to 639 and 479 and the window to 20.
`timescale 1ns / 1ps

module mouse_pointer_click_tracker (
  input  logic          clk,
  input  logic          rst,
  mpct_poll_if.sink     poll,
  mpct_result_if.source result,
  mpct_cfg_if.sink      cfg
);

  // Configuration registers. The port never stalls.
  logic [mpct_pkg::CoordW-1:0] x_limit;
  logic [mpct_pkg::CoordW-1:0] y_limit;
  logic [mpct_pkg::CountW-1:0] window;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= mpct_pkg::X_LIMIT_RESET;
      y_limit <= mpct_pkg::Y_LIMIT_RESET;
      window  <= mpct_pkg::WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mpct_pkg::REG_X_LIMIT: x_limit <= cfg.data;
        mpct_pkg::REG_Y_LIMIT: y_limit <= cfg.data;
        mpct_pkg::REG_WINDOW:  window  <= cfg.data[mpct_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. It moves on whenever the compute stage can load the
  // result register, so a stalled result holds both stages in place.
  logic              in_valid;
  logic signed [7:0] x_q;
  logic signed [7:0] y_q;
  logic [2:0]        raw_n_q;
  logic              res_valid;
  logic              advance;

  assign advance    = in_valid && (!res_valid || result.ready);
  assign poll.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      x_q     <= poll.x_counter;
      y_q     <= poll.y_counter;
      raw_n_q <= {poll.middle_raw_n, poll.right_raw_n, poll.left_raw_n};
    end
  end

  // Movement state: previous counters and the cursor.
  logic signed [7:0]                 last_x;
  logic signed [7:0]                 last_y;
  logic [mpct_pkg::CoordW-1:0]       cursor_x;
  logic [mpct_pkg::CoordW-1:0]       cursor_y;
  logic signed [mpct_pkg::DeltaW-1:0] dx;
  logic signed [mpct_pkg::DeltaW-1:0] dy;
  logic [mpct_pkg::CoordW-1:0]       cursor_x_next;
  logic [mpct_pkg::CoordW-1:0]       cursor_y_next;

  always_comb begin
    dx = mpct_pkg::wrap_delta(x_q, last_x);
    dy = mpct_pkg::wrap_delta(y_q, last_y);
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    // Both axes move together, and only when something moved at all.
    if (dx != '0 || dy != '0) begin
      cursor_x_next = mpct_pkg::move_axis(cursor_x, dx, x_limit);
      cursor_y_next = mpct_pkg::move_axis(cursor_y, dy, y_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x   <= '0;
      last_y   <= '0;
      cursor_x <= 12'd1;
      cursor_y <= 12'd1;
    end else if (advance) begin
      last_x   <= x_q;
      last_y   <= y_q;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  // Buttons, bit 0 left, bit 1 right, bit 2 middle.
  mpct_pkg::btn_status_t btn_status [3];

  for (genvar b = 0; b < 3; b++) begin : g_btn
    mpct_button u_button (
      .clk    (clk),
      .rst    (rst),
      .step   (advance),
      .raw_n  (raw_n_q[b]),
      .window (window),
      .status (btn_status[b])
    );
  end

  // Result register.
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.pointer_x    <= cursor_x_next;
      result.pointer_y    <= cursor_y_next;
      result.delta_x      <= dx;
      result.delta_y      <= dy;
      result.left_down    <= btn_status[0].down;
      result.left_event   <= btn_status[0].ev;
      result.right_down   <= btn_status[1].down;
      result.right_event  <= btn_status[1].ev;
      result.middle_down  <= btn_status[2].down;
      result.middle_event <= btn_status[2].ev;
    end
  end

endmodule
